// ===== design/sbtm_pkg.sv =====
// ----------------------------------------------------------------------------
// Spike buffer timestamp merge: shared package
// Field widths, default sizes, operation and status codes, the sequencer
// states and the control group that the top level sends to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package sbtm_pkg;

  // Default sizes of the buffer bank.
  localparam int NUM_BUFFERS_DEF  = 16;
  localparam int BUFFER_DEPTH_DEF = 256;
  localparam int NEURON_BITS_DEF  = 16;

  // Fixed field widths of the stream beats.
  localparam int MODE_W   = 2;
  localparam int BIDX_W   = 4;
  localparam int SRC_W    = 16;
  localparam int TS_W     = 8;
  localparam int NEU_W    = 16;
  localparam int STATUS_W = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // Operation carried by an input beat.
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_POP    = 2'd2
  } mode_t;

  // Status carried by a result beat.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT
  } state_t;

  // Commands broadcast to every cell; sel gates append and commit.
  typedef struct packed {
    logic clear;
    logic append;
    logic commit;
  } cell_ctl_t;

endpackage : sbtm_pkg

`default_nettype wire

// ===== design/sbtm_ram.sv =====
// ----------------------------------------------------------------------------
// Spike buffer timestamp merge: generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbtm_ram
  import sbtm_pkg::*;
#(
  parameter int WIDTH = TS_W + NEURON_BITS_DEF,
  parameter int DEPTH = BUFFER_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : sbtm_ram

`default_nettype wire

// ===== design/sbtm_cell.sv =====
// ----------------------------------------------------------------------------
// Spike buffer timestamp merge: buffer cell
// One spike buffer with its own entry RAM, fill count, read pointer and
// source tag, plus one stage of the registered minimum chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sbtm_cell
  import sbtm_pkg::*;
#(
  parameter int NUM_BUFFERS  = NUM_BUFFERS_DEF,
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int NEURON_BITS  = NEURON_BITS_DEF,
  parameter int IDX          = 0,
  localparam int IW          = $clog2(NUM_BUFFERS)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cell_ctl_t              ctl,
  input  wire logic                   sel,
  input  wire logic [TS_W-1:0]        wr_ts,
  input  wire logic [NEURON_BITS-1:0] wr_neuron,
  input  wire logic [SRC_W-1:0]       wr_src,
  // Best head so far, from the neighbor on the left.
  input  wire logic                   l_vld,
  input  wire logic [TS_W-1:0]        l_ts,
  input  wire logic [NEURON_BITS-1:0] l_neuron,
  input  wire logic [SRC_W-1:0]       l_src,
  input  wire logic [IW-1:0]          l_idx,
  // Best head including this cell, to the neighbor on the right.
  output logic                        r_vld_r,
  output logic      [TS_W-1:0]        r_ts_r,
  output logic      [NEURON_BITS-1:0] r_neuron_r,
  output logic      [SRC_W-1:0]       r_src_r,
  output logic      [IW-1:0]          r_idx_r,
  output logic                        drained,
  output logic                        accepted
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int EW = TS_W + NEURON_BITS;

  logic [CW-1:0]    fill_r;
  logic [CW-1:0]    rptr_r;
  logic [SRC_W-1:0] tag_r;
  logic [EW-1:0]    head;
  logic             head_vld;
  logic             full;
  logic             take;

  // Entry store of this buffer, read at the read pointer every cycle.
  sbtm_ram #(
    .WIDTH (EW),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accepted),
    .waddr (fill_r[AW-1:0]),
    .wdata ({wr_ts, wr_neuron}),
    .raddr (rptr_r[AW-1:0]),
    .rdata (head)
  );

  // Buffer status.
  assign full     = (fill_r == CW'(BUFFER_DEPTH));
  assign head_vld = (rptr_r < fill_r);
  assign drained  = (rptr_r == fill_r);
  assign accepted = ctl.append && sel && !full;

  // Fill count, read pointer and source tag.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      fill_r <= '0;
      rptr_r <= '0;
      tag_r  <= '0;
    end else begin
      if (accepted) begin
        fill_r <= fill_r + CW'(1);
        tag_r  <= wr_src;
      end
      if (ctl.commit && sel) begin
        rptr_r <= rptr_r + CW'(1);
      end
    end
  end

  // The left neighbor wins ties since it has the lower buffer index.
  assign take = head_vld && (!l_vld || (head[EW-1:NEURON_BITS] < l_ts));

  // Chain stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else begin
      r_vld_r <= take || l_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      r_ts_r     <= head[EW-1:NEURON_BITS];
      r_neuron_r <= head[NEURON_BITS-1:0];
      r_src_r    <= tag_r;
      r_idx_r    <= IW'(IDX);
    end else begin
      r_ts_r     <= l_ts;
      r_neuron_r <= l_neuron;
      r_src_r    <= l_src;
      r_idx_r    <= l_idx;
    end
  end

endmodule : sbtm_cell

`default_nettype wire

// ===== design/spike_buffer_timestamp_merge_unit.sv =====
// ----------------------------------------------------------------------------
// Spike buffer timestamp merge unit
// Merges a bank of per-source spike buffers by timestamp.
// ----------------------------------------------------------------------------
// Usage:
// The in_ channel takes one command per beat: begin batch, append a spike
// to a buffer, or pop the spike with the smallest timestamp (lowest buffer
// index wins ties). Every command gives exactly one beat on the out_
// channel, carrying a status, the popped spike and the all-drained flag.
// One command is in flight at a time. Begin batch and append pass from the
// execute state straight to the result; a pop also scans the bank through
// the registered minimum chain, which moves the best head one buffer cell
// per cycle, and forms its result when the scan ends.
// The result sits in an output register; while the receiver stalls it is
// held, and the next result waits in the emit state for that register.
// After reset all fill counts, read pointers and tags are zero and the
// block accepts commands at once; entry RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module spike_buffer_timestamp_merge_unit
  import sbtm_pkg::*;
#(
  parameter int NUM_BUFFERS  = NUM_BUFFERS_DEF,
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int NEURON_BITS  = NEURON_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // buffer_index[3:0], source_id[19:4], spike_ts[27:20], spike_neuron[43:28]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  wire logic [MODE_W-1:0]     in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_ts[7:0], out_neuron[23:8], out_buffer[27:24], out_source[43:28],
  // all_drained[44]
  output logic      [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic      [STATUS_W-1:0]   out_tuser
);

  localparam int IW  = $clog2(NUM_BUFFERS);
  localparam int SCW = $clog2(NUM_BUFFERS);

  // Sequencer and held command.
  state_t                 state_r, state_nxt;
  mode_t                  mode_r;
  logic [BIDX_W-1:0]      bidx_r;
  logic [SRC_W-1:0]       src_r;
  logic [TS_W-1:0]        ts_r;
  logic [NEURON_BITS-1:0] neu_r;
  logic                   drained_r;
  logic [SCW-1:0]         scan_cnt_r;
  logic                   scan_done;

  // Result held until the output register is free.
  status_t                res_status_r;
  logic [TS_W-1:0]        res_ts_r;
  logic [NEU_W-1:0]       res_neu_r;
  logic [BIDX_W-1:0]      res_buf_r;
  logic [SRC_W-1:0]       res_src_r;

  // Output register.
  logic                   out_vld_r;
  status_t                out_status_r;
  logic [TS_W-1:0]        out_ts_r;
  logic [NEU_W-1:0]       out_neu_r;
  logic [BIDX_W-1:0]      out_buf_r;
  logic [SRC_W-1:0]       out_src_r;
  logic                   out_drained_r;

  // Cell array signals.
  cell_ctl_t              ctl;
  logic [NUM_BUFFERS-1:0] sel;
  logic [NUM_BUFFERS-1:0] drained_vec;
  logic [NUM_BUFFERS-1:0] acc_vec;
  logic                   chain_vld    [NUM_BUFFERS+1];
  logic [TS_W-1:0]        chain_ts     [NUM_BUFFERS+1];
  logic [NEURON_BITS-1:0] chain_neuron [NUM_BUFFERS+1];
  logic [SRC_W-1:0]       chain_src    [NUM_BUFFERS+1];
  logic [IW-1:0]          chain_idx    [NUM_BUFFERS+1];

  logic                   in_accept;
  logic                   out_load;

  assign in_accept = in_tvalid && in_tready;
  assign out_load  = (state_r == S_EMIT) && (!out_vld_r || out_tready);
  assign scan_done = (scan_cnt_r == SCW'(NUM_BUFFERS - 1));

  // The chain starts with no candidate.
  assign chain_vld[0]    = 1'b0;
  assign chain_ts[0]     = '0;
  assign chain_neuron[0] = '0;
  assign chain_src[0]    = '0;
  assign chain_idx[0]    = '0;

  // Row of buffer cells.
  for (genvar i = 0; i < NUM_BUFFERS; i++) begin : g_cell
    sbtm_cell #(
      .NUM_BUFFERS  (NUM_BUFFERS),
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .NEURON_BITS  (NEURON_BITS),
      .IDX          (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .sel        (sel[i]),
      .wr_ts      (ts_r),
      .wr_neuron  (neu_r),
      .wr_src     (src_r),
      .l_vld      (chain_vld[i]),
      .l_ts       (chain_ts[i]),
      .l_neuron   (chain_neuron[i]),
      .l_src      (chain_src[i]),
      .l_idx      (chain_idx[i]),
      .r_vld_r    (chain_vld[i+1]),
      .r_ts_r     (chain_ts[i+1]),
      .r_neuron_r (chain_neuron[i+1]),
      .r_src_r    (chain_src[i+1]),
      .r_idx_r    (chain_idx[i+1]),
      .drained    (drained_vec[i]),
      .accepted   (acc_vec[i])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = (mode_r == MODE_POP) ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Cell commands: clear and append in the execute cycle, pop commit at scan end.
  always_comb begin
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_EXEC: begin
        ctl.clear  = (mode_r == MODE_CLEAR);
        ctl.append = (mode_r == MODE_APPEND);
      end
      S_SCAN: begin
        ctl.commit = scan_done && chain_vld[NUM_BUFFERS];
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // Cell select: the append target, or the pop winner during the scan.
  always_comb begin
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      if (state_r == S_EXEC) begin
        sel[i] = (32'(bidx_r) == i);
      end else begin
        sel[i] = (32'(chain_idx[NUM_BUFFERS]) == i);
      end
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      scan_cnt_r <= '0;
    end else if (state_r == S_SCAN) begin
      scan_cnt_r <= scan_cnt_r + SCW'(1);
    end
  end

  // Command capture; the drained flag reflects the bank before the command.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r    <= mode_t'(in_tuser);
      bidx_r    <= in_tdata[3:0];
      src_r     <= in_tdata[19:4];
      ts_r      <= in_tdata[27:20];
      neu_r     <= NEURON_BITS'(in_tdata[43:28]);
      drained_r <= &drained_vec;
    end
  end

  // Result formation.
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      res_status_r <= STATUS_OK;
      res_ts_r     <= '0;
      res_neu_r    <= '0;
      res_buf_r    <= '0;
      res_src_r    <= '0;
      if ((mode_r == MODE_APPEND) && !(|acc_vec)) begin
        res_status_r <= STATUS_OVERFLOW;
      end
    end else if ((state_r == S_SCAN) && scan_done) begin
      if (chain_vld[NUM_BUFFERS]) begin
        res_status_r <= STATUS_OK;
        res_ts_r     <= chain_ts[NUM_BUFFERS];
        res_neu_r    <= NEU_W'(chain_neuron[NUM_BUFFERS]);
        res_buf_r    <= BIDX_W'(chain_idx[NUM_BUFFERS]);
        res_src_r    <= chain_src[NUM_BUFFERS];
      end else begin
        res_status_r <= STATUS_EMPTY;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_ts_r      <= res_ts_r;
      out_neu_r     <= res_neu_r;
      out_buf_r     <= res_buf_r;
      out_src_r     <= res_src_r;
      out_drained_r <= drained_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_drained_r, out_src_r, out_buf_r, out_neu_r, out_ts_r};

`ifndef SYNTHESIS
  // An append lands in at most one buffer.
  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(acc_vec))
    else $error("append accepted by more than one buffer");

  // A pop commit advances exactly one buffer.
  assert property (@(posedge clk) disable iff (!rst_n) ctl.commit |-> $onehot(sel))
    else $error("pop commit does not select exactly one buffer");

  // After a begin batch every buffer reads as drained.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && (mode_r == MODE_CLEAR)) |=> (&drained_vec))
    else $error("buffers not drained after begin batch");

  // A new command is taken only while no result is waiting to be formed.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> ((state_r == S_EXEC) && !ctl.commit))
    else $error("command accepted outside the idle state");
`endif

endmodule : spike_buffer_timestamp_merge_unit

`default_nettype wire

// ===== sim/tb_spike_buffer_timestamp_merge_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the spike buffer timestamp merge unit
// Drives begin-batch, append and pop commands with random gaps on the
// command side and random stalls on the result side. A model of the buffer
// bank kept in the bench predicts every result beat, and each one is
// compared field by field.
// ----------------------------------------------------------------------------

module tb_spike_buffer_timestamp_merge_unit;
  import sbtm_pkg::*;

  localparam int NB              = NUM_BUFFERS_DEF;
  localparam int DEPTH           = BUFFER_DEPTH_DEF;
  localparam int AW              = $clog2(DEPTH);
  localparam int WATCHDOG_CYCLES = 2000;

  // One predicted result beat.
  typedef struct packed {
    status_t           status;
    logic [TS_W-1:0]   ts;
    logic [NEU_W-1:0]  neuron;
    logic [BIDX_W-1:0] origin;
    logic [SRC_W-1:0]  source;
    logic              drained;
  } merge_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // Bench copy of the buffer bank.
  logic [TS_W-1:0]  ts_mem   [NB][DEPTH];
  logic [NEU_W-1:0] neu_mem  [NB][DEPTH];
  logic [8:0]       rd_ptr   [NB];
  logic [8:0]       fill_cnt [NB];
  logic [SRC_W-1:0] src_tag  [NB];

  merge_result_t merge_expect [$];
  merge_result_t want_beat;
  int            err_count     = 0;
  int            cmds_accepted = 0;
  int            stall_left    = 0;
  int            idle_cycles   = 0;
  bit            quiet         = 1'b0;

  spike_buffer_timestamp_merge_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Number of spikes still waiting in the bench copy of the bank.
  function automatic int pending_spikes();
    int total;
    total = 0;
    for (int b = 0; b < NB; b++) total += int'(fill_cnt[b]) - int'(rd_ptr[b]);
    return total;
  endfunction

  // Applies one command to the bench copy and returns the result it gives.
  function automatic merge_result_t merge_predict(mode_t op, logic [BIDX_W-1:0] bidx,
                                                  logic [SRC_W-1:0] src,
                                                  logic [TS_W-1:0] ts,
                                                  logic [NEU_W-1:0] neu);
    merge_result_t    r;
    logic             found;
    logic [3:0]       best;
    logic [TS_W-1:0]  best_ts;
    logic [TS_W-1:0]  head;
    r         = '0;
    r.status  = STATUS_OK;
    r.drained = (pending_spikes() == 0);
    found     = 1'b0;
    best      = '0;
    best_ts   = '0;
    case (op)
      MODE_CLEAR: begin
        for (int b = 0; b < NB; b++) begin
          rd_ptr[b]   = '0;
          fill_cnt[b] = '0;
          src_tag[b]  = '0;
        end
      end
      MODE_APPEND: begin
        if (int'(fill_cnt[bidx]) >= DEPTH) begin
          r.status = STATUS_OVERFLOW;
        end else begin
          ts_mem[bidx][fill_cnt[bidx][AW-1:0]]  = ts;
          neu_mem[bidx][fill_cnt[bidx][AW-1:0]] = neu;
          fill_cnt[bidx] = fill_cnt[bidx] + 9'd1;
          src_tag[bidx]  = src;
        end
      end
      MODE_POP: begin
        // Strict less-than keeps the lowest buffer index on a tie.
        for (int b = 0; b < NB; b++) begin
          if (rd_ptr[b] < fill_cnt[b]) begin
            head = ts_mem[b][rd_ptr[b][AW-1:0]];
            if (!found || head < best_ts) begin
              found   = 1'b1;
              best    = b[3:0];
              best_ts = head;
            end
          end
        end
        if (!found) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.ts     = ts_mem[best][rd_ptr[best][AW-1:0]];
          r.neuron = neu_mem[best][rd_ptr[best][AW-1:0]];
          r.origin = best;
          r.source = src_tag[best];
          rd_ptr[best] = rd_ptr[best] + 9'd1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sends one command beat and records the result it should give.
  task automatic send_cmd(mode_t op, logic [BIDX_W-1:0] bidx, logic [SRC_W-1:0] src,
                          logic [TS_W-1:0] ts, logic [NEU_W-1:0] neu);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'h0, neu, ts, src, bidx};
    do @(posedge clk); while (!in_tready);
    merge_expect.push_back(merge_predict(op, bidx, src, ts, neu));
    cmds_accepted++;
  endtask

  task automatic random_append(logic [3:0] bmask, logic [TS_W-1:0] ts_max);
    send_cmd(MODE_APPEND, BIDX_W'($urandom) & bmask, SRC_W'($urandom),
             TS_W'($urandom_range(0, ts_max)), NEU_W'($urandom));
  endtask

  task automatic random_pop();
    send_cmd(MODE_POP, BIDX_W'($urandom), SRC_W'($urandom), TS_W'($urandom),
             NEU_W'($urandom));
  endtask

  // Field extremes, timestamp ties, retagging and clearing a loaded bank.
  task automatic test_directed();
    send_cmd(MODE_POP,    4'd0,  16'h0000, 8'd0,   16'h0000);
    send_cmd(MODE_CLEAR,  4'd15, 16'hFFFF, 8'd255, 16'hFFFF);
    send_cmd(MODE_APPEND, 4'd0,  16'hFFFF, 8'd255, 16'hFFFF);
    send_cmd(MODE_APPEND, 4'd15, 16'h0000, 8'd0,   16'h0000);
    send_cmd(MODE_APPEND, 4'd7,  16'hA5A5, 8'd0,   16'h1234);
    send_cmd(MODE_APPEND, 4'd15, 16'h5A5A, 8'd0,   16'h8001);
    send_cmd(MODE_APPEND, 4'd0,  16'h0F0F, 8'd128, 16'h7FFE);
    send_cmd(MODE_APPEND, 4'd8,  16'hF0F0, 8'd254, 16'hAAAA);
    repeat (7) send_cmd(MODE_POP, 4'd0, 16'h0000, 8'd0, 16'h0000);
    send_cmd(MODE_APPEND, 4'd3,  16'h1111, 8'd10,  16'h5555);
    send_cmd(MODE_APPEND, 4'd12, 16'h2222, 8'd10,  16'h0001);
    // Clearing with spikes still queued must report the bank as not drained.
    send_cmd(MODE_CLEAR,  4'd0,  16'h0000, 8'd0,   16'h0000);
    send_cmd(MODE_POP,    4'd15, 16'hFFFF, 8'd255, 16'hFFFF);
  endtask

  // Fills one buffer to the brim, then appends past the end.
  task automatic test_overflow();
    send_cmd(MODE_CLEAR, 4'd0, 16'h0000, 8'd0, 16'h0000);
    repeat (DEPTH) send_cmd(MODE_APPEND, 4'd9, 16'h3C3C, TS_W'($urandom), NEU_W'($urandom));
    send_cmd(MODE_APPEND, 4'd9, 16'hBEEF, 8'd0, 16'hFFFF);
    send_cmd(MODE_APPEND, 4'd9, 16'hFFFF, 8'd255, 16'h0000);
    send_cmd(MODE_APPEND, 4'd4, 16'h4444, 8'd0, 16'h0444);
    repeat (6) random_pop();
  endtask

  // Batches of appends followed by a drain, with stray commands mixed in.
  task automatic test_random_merge(int target);
    int              n_app;
    int              roll;
    logic [3:0]      bmask;
    logic [TS_W-1:0] ts_max;
    while (cmds_accepted < target) begin
      quiet = ($urandom_range(0, 3) == 0);
      bmask = BIDX_W'($urandom_range(0, 15));
      case ($urandom_range(0, 2))
        0:       ts_max = 8'd3;
        1:       ts_max = 8'd31;
        default: ts_max = 8'd255;
      endcase
      send_cmd(MODE_CLEAR, BIDX_W'($urandom), SRC_W'($urandom), TS_W'($urandom),
               NEU_W'($urandom));
      n_app = $urandom_range(1, 40);
      repeat (n_app) random_append(bmask, ts_max);
      while (pending_spikes() > 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) random_append(bmask, ts_max);
        else if (roll < 14) send_cmd(MODE_CLEAR, BIDX_W'($urandom), SRC_W'($urandom),
                                     TS_W'($urandom), NEU_W'($urandom));
        else random_pop();
      end
      repeat ($urandom_range(0, 2)) random_pop();
    end
    quiet = 1'b0;
  endtask

  task automatic flag_field(string name, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      err_count++;
    end
  endtask

  // Result side: check every accepted beat, then pick the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (merge_expect.size() == 0) begin
        $error("result beat with no command pending");
        err_count++;
      end else begin
        want_beat = merge_expect.pop_front();
        flag_field("status",      16'(want_beat.status),  16'(out_tuser));
        flag_field("out_ts",      16'(want_beat.ts),      16'(out_tdata[7:0]));
        flag_field("out_neuron",  want_beat.neuron,       out_tdata[23:8]);
        flag_field("out_buffer",  16'(want_beat.origin),  16'(out_tdata[27:24]));
        flag_field("out_source",  want_beat.source,       out_tdata[43:28]);
        flag_field("all_drained", 16'(want_beat.drained), 16'(out_tdata[44]));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_tready <= (stall_left == 0);
    end
  end

  // Watchdog on cycles where neither side moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("tb_spike_buffer_timestamp_merge_unit: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_CLEAR;
    for (int b = 0; b < NB; b++) begin
      rd_ptr[b]   = '0;
      fill_cnt[b] = '0;
      src_tag[b]  = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_overflow();
    test_random_merge(1700);

    in_tvalid <= 1'b0;
    while (merge_expect.size() != 0) @(posedge clk);
    repeat (NB + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_spike_buffer_timestamp_merge_unit: clean");
    end else begin
      $display("tb_spike_buffer_timestamp_merge_unit: errors");
    end
    $finish;
  end

endmodule
